// ===== rtl/iibs_pkg.sv =====
// Shared types and constants for the integral image box sum block.
// No dependencies; imported by every module of the block.
package iibs_pkg;

    localparam int CFG_W      = 10;
    localparam int PIX_W      = 8;
    localparam int QF_W       = 10;
    localparam int ENTRY_W    = 26;
    localparam int RSUM_W     = 17;
    localparam int SUM_W      = ENTRY_W + 2;
    localparam int APB_DW     = 32;
    localparam int PADDR_W    = 3;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;

    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] image_cols;
        logic [CFG_W-1:0] image_rows;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_CALC,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_RD3,
        S_Q_DONE
    } t_state;

endpackage

// ===== rtl/iibs_regs.sv =====
// APB register block for the integral image box sum: image width and height.
// Depends on iibs_pkg.
module iibs_regs import iibs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [CFG_W-1:0] r_image_cols;
    logic [CFG_W-1:0] r_image_rows;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= CFG_RESET;
            r_image_rows <= CFG_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_ROWS) begin
                r_image_rows <= pwdata[CFG_W-1:0];
            end else begin
                r_image_cols <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ROWS) begin
            prdata = APB_DW'(r_image_rows);
        end else begin
            prdata = APB_DW'(r_image_cols);
        end
    end

    assign o_cfg.image_cols = r_image_cols;
    assign o_cfg.image_rows = r_image_rows;

endmodule

// ===== rtl/integral_image_box_sum.sv =====
// Load: each transaction reads the entry above (unless on row 0), then writes one entry.
// Query: no new input is taken until the result is registered at the output;
// the four corner reads share the single read port of the table memory.
// Reset is synchronous, active low: clears control, load position, running sum and
// registers (512 x 512); table memory contents are not cleared.
// Depends on iibs_pkg and iibs_regs.
module integral_image_box_sum import iibs_pkg::*; #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel[7:0], q_row[17:8], q_col[27:18], q_height[37:28], q_width[47:38]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // box_sum[25:0], zero above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int CNT_C   = $clog2(MAX_COLS + 1);
    localparam int CNT_R   = $clog2(MAX_ROWS + 1);
    localparam int IDX_C   = $clog2(MAX_COLS);
    localparam int IDX_R   = $clog2(MAX_ROWS);
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_MAX = (CNT_C > CNT_R) ? CNT_C : CNT_R;
    localparam int QW      = ((CNT_MAX + 2) > 13) ? (CNT_MAX + 2) : 13;
    localparam logic signed [QW-1:0] ONE_S = QW'(1);

    t_cfg cfg;

    iibs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state r_state, n_state;

    logic [PIX_W-1:0]         r_pix;
    logic signed [QF_W-1:0]   r_qrow;
    logic signed [QF_W-1:0]   r_qcol;
    logic [QF_W-1:0]          r_qh;
    logic [QF_W-1:0]          r_qw;
    logic [IDX_R-1:0]         r_load_row;
    logic [IDX_C-1:0]         r_load_col;
    logic [RSUM_W-1:0]        r_rsum;
    logic                     r_above_ok;
    logic signed [QW-1:0]     r_r1, r_r2, r_c1, r_c2;
    logic                     r_rd_ok;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [ENTRY_W-1:0]       r_out_data;
    logic [ENTRY_W-1:0]       r_mem [DEPTH];
    logic [ENTRY_W-1:0]       r_rd_data;

    logic [CNT_C-1:0]         eff_c;
    logic [CNT_R-1:0]         eff_r;
    logic                     s_acc;
    logic                     out_free;
    logic                     restart;
    logic [IDX_R-1:0]         ld_row_e;
    logic [IDX_C-1:0]         ld_col_e;
    logic                     rd_en;
    logic                     wr_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]       wr_data;
    logic                     corner_ok;
    logic signed [QW-1:0]     sel_r, sel_c;
    logic signed [QW-1:0]     q_r, q_c, q_re, q_ce, rows_s, cols_s;
    logic signed [SUM_W-1:0]  term;
    logic signed [SUM_W-1:0]  final_sum;
    logic [CNT_C-1:0]         col_inc;
    logic [CNT_R-1:0]         row_inc;

    always_comb begin
        if (cfg.image_cols == '0) begin
            eff_c = CNT_C'(1);
        end else if (32'(cfg.image_cols) > MAX_COLS) begin
            eff_c = CNT_C'(MAX_COLS);
        end else begin
            eff_c = CNT_C'(cfg.image_cols);
        end
        if (cfg.image_rows == '0) begin
            eff_r = CNT_R'(1);
        end else if (32'(cfg.image_rows) > MAX_ROWS) begin
            eff_r = CNT_R'(MAX_ROWS);
        end else begin
            eff_r = CNT_R'(cfg.image_rows);
        end
    end

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign restart  = (CNT_C'(r_load_col) >= eff_c) || (CNT_R'(r_load_row) >= eff_r);
    assign ld_row_e = restart ? '0 : r_load_row;
    assign ld_col_e = restart ? '0 : r_load_col;
    assign col_inc  = CNT_C'(r_load_col) + CNT_C'(1);
    assign row_inc  = CNT_R'(r_load_row) + CNT_R'(1);

    assign q_r    = QW'(r_qrow);
    assign q_c    = QW'(r_qcol);
    assign q_re   = q_r + $signed(QW'(r_qh));
    assign q_ce   = q_c + $signed(QW'(r_qw));
    assign rows_s = $signed(QW'(eff_r));
    assign cols_s = $signed(QW'(eff_c));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (s_axis_tuser[0] == ACT_QUERY) ? S_Q_CALC : S_LD_RD;
                end
            end
            S_LD_RD:  n_state = S_LD_WR;
            S_LD_WR:  n_state = S_IDLE;
            S_Q_CALC: n_state = S_Q_RD0;
            S_Q_RD0:  n_state = S_Q_RD1;
            S_Q_RD1:  n_state = S_Q_RD2;
            S_Q_RD2:  n_state = S_Q_RD3;
            S_Q_RD3:  n_state = S_Q_DONE;
            S_Q_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        sel_r         = r_r1;
        sel_c         = r_c1;
        rd_addr       = ADDR_W'(ld_row_e - IDX_R'(1)) * ADDR_W'(MAX_COLS) + ADDR_W'(ld_col_e);
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_LD_RD: rd_en = (ld_row_e != '0);
            S_LD_WR: wr_en = 1'b1;
            S_Q_RD0: begin
                rd_en = 1'b1;
            end
            S_Q_RD1: begin
                rd_en = 1'b1;
                sel_c = r_c2;
            end
            S_Q_RD2: begin
                rd_en = 1'b1;
                sel_r = r_r2;
            end
            S_Q_RD3: begin
                rd_en = 1'b1;
                sel_r = r_r2;
                sel_c = r_c2;
            end
            default: ;
        endcase
        if (r_state != S_LD_RD) begin
            rd_addr = ADDR_W'(IDX_R'(sel_r)) * ADDR_W'(MAX_COLS) + ADDR_W'(IDX_C'(sel_c));
        end
    end

    assign corner_ok = !sel_r[QW-1] && !sel_c[QW-1];
    assign wr_addr   = ADDR_W'(r_load_row) * ADDR_W'(MAX_COLS) + ADDR_W'(r_load_col);
    assign wr_data   = ENTRY_W'(r_rsum) + (r_above_ok ? r_rd_data : '0);
    assign term      = r_rd_ok ? $signed(SUM_W'(r_rd_data)) : '0;
    assign final_sum = r_acc + term;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_rsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LD_RD) begin
                r_load_row <= ld_row_e;
                r_load_col <= ld_col_e;
                r_rsum     <= (restart ? '0 : r_rsum) + RSUM_W'(r_pix);
            end
            if (r_state == S_LD_WR) begin
                if (col_inc >= eff_c) begin
                    r_load_col <= '0;
                    r_rsum     <= '0;
                    r_load_row <= (row_inc >= eff_r) ? '0 : IDX_R'(row_inc);
                end else begin
                    r_load_col <= IDX_C'(col_inc);
                end
            end
            if (r_state == S_Q_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pix  <= s_axis_tdata[7:0];
            r_qrow <= s_axis_tdata[17:8];
            r_qcol <= s_axis_tdata[27:18];
            r_qh   <= s_axis_tdata[37:28];
            r_qw   <= s_axis_tdata[47:38];
        end
        if (r_state == S_LD_RD) begin
            r_above_ok <= (ld_row_e != '0);
        end
        if (r_state == S_Q_CALC) begin
            r_r1 <= ((q_r < rows_s) ? q_r : rows_s) - ONE_S;
            r_c1 <= ((q_c < cols_s) ? q_c : cols_s) - ONE_S;
            r_r2 <= ((q_re < rows_s) ? q_re : rows_s) - ONE_S;
            r_c2 <= ((q_ce < cols_s) ? q_ce : cols_s) - ONE_S;
        end
        if (rd_en) begin
            r_rd_ok <= corner_ok;
        end
        case (r_state)
            S_Q_RD1: r_acc <= term;
            S_Q_RD2: r_acc <= r_acc - term;
            S_Q_RD3: r_acc <= r_acc - term;
            default: ;
        endcase
        if (r_state == S_Q_DONE && out_free) begin
            r_out_data <= final_sum[SUM_W-1] ? '0 : final_sum[ENTRY_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

// ===== rtl/iibs_checker.sv =====
// Port-level checks for integral_image_box_sum, attached by bind.
// Depends on iibs_pkg and the top level integral_image_box_sum.
module iibs_checker import iibs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid not cleared by reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after input transaction");

endmodule

bind integral_image_box_sum iibs_checker u_iibs_checker (.*);
